/* design/roz_pkg.sv */
// Package: shared types and constants for the rotate-and-zoom address generator.
package roz_pkg;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_LINE  = 2'd2;

   localparam int FRAME_LINE_OFFSET  = 16;
   localparam int FRAME_PIXEL_OFFSET = 89;
   localparam int START_SHIFT        = 8;
   localparam int STEP_SHIFT         = 5;
   localparam int FRAC_BITS          = 16;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_START_X          = 3'd0;
   localparam logic [2:0] REG_START_Y          = 3'd1;
   localparam logic [2:0] REG_STEP_X_PER_PIXEL = 3'd2;
   localparam logic [2:0] REG_STEP_X_PER_LINE  = 3'd3;
   localparam logic [2:0] REG_STEP_Y_PER_PIXEL = 3'd4;
   localparam logic [2:0] REG_STEP_Y_PER_LINE  = 3'd5;
   localparam logic [2:0] REG_WRAP_MODE        = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [8:0] crop_left;
      logic [8:0] crop_top;
   } req_type;

   typedef struct packed {
      logic [8:0] source_x;
      logic [8:0] source_y;
      logic       inside_res;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] step_x_per_pixel;
      logic signed [15:0] step_x_per_line;
      logic signed [15:0] step_y_per_pixel;
      logic signed [15:0] step_y_per_line;
      logic               wrap_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] base_x;
      logic [31:0] crop_px_x;
      logic [31:0] crop_ln_x;
      logic [31:0] base_y;
      logic [31:0] crop_px_y;
      logic [31:0] crop_ln_y;
   } stage_type;

endpackage

/* design/roz_csr.sv */
// Configuration register file with APB-style access.
module roz_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [roz_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [roz_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [roz_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output roz_pkg::cfg_type               cfg
);
   import roz_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_START_X:          cfg_in.start_x          = csr_pwdata[15:0];
            REG_START_Y:          cfg_in.start_y          = csr_pwdata[15:0];
            REG_STEP_X_PER_PIXEL: cfg_in.step_x_per_pixel = csr_pwdata[15:0];
            REG_STEP_X_PER_LINE:  cfg_in.step_x_per_line  = csr_pwdata[15:0];
            REG_STEP_Y_PER_PIXEL: cfg_in.step_y_per_pixel = csr_pwdata[15:0];
            REG_STEP_Y_PER_LINE:  cfg_in.step_y_per_line  = csr_pwdata[15:0];
            REG_WRAP_MODE:        cfg_in.wrap_mode        = csr_pwdata[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_START_X:          csr_prdata = {16'd0, cfg_ff.start_x};
         REG_START_Y:          csr_prdata = {16'd0, cfg_ff.start_y};
         REG_STEP_X_PER_PIXEL: csr_prdata = {16'd0, cfg_ff.step_x_per_pixel};
         REG_STEP_X_PER_LINE:  csr_prdata = {16'd0, cfg_ff.step_x_per_line};
         REG_STEP_Y_PER_PIXEL: csr_prdata = {16'd0, cfg_ff.step_y_per_pixel};
         REG_STEP_Y_PER_LINE:  csr_prdata = {16'd0, cfg_ff.step_y_per_line};
         REG_WRAP_MODE:        csr_prdata = {31'd0, cfg_ff.wrap_mode};
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/roz_front.sv */
// Input register stage: captures a transaction and forms the frame-start product terms.
module roz_front #(
   parameter int X_ADJUST = 0,
   parameter int Y_ADJUST = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  roz_pkg::req_type   req_payload,
   input  roz_pkg::cfg_type   cfg,
   input  logic               out_ready,
   output logic               stage_fire,
   output roz_pkg::stage_type stage
);
   import roz_pkg::*;

   localparam logic signed [10:0] K_LINE  = 11'(FRAME_LINE_OFFSET + Y_ADJUST);
   localparam logic signed [10:0] K_PIXEL = 11'(FRAME_PIXEL_OFFSET + X_ADJUST);

   logic      stage_valid_ff, stage_valid_in;
   stage_type stage_ff, stage_in;
   logic      load;

   logic signed [26:0] adj_line_x, adj_pixel_x, adj_line_y, adj_pixel_y;
   logic signed [25:0] crop_px_x, crop_ln_x, crop_px_y, crop_ln_y;
   logic signed [9:0]  crop_l_s, crop_t_s;
   logic [31:0]        start_term_x, start_term_y;
   logic [31:0]        base_pre_x, base_pre_y;

   assign stage_fire = stage_valid_ff && (stage_ff.kind != KIND_PIXEL || out_ready);
   assign req_stall  = stage_valid_ff && !stage_fire;
   assign load       = req_valid && !req_stall;

   assign crop_l_s = $signed({1'b0, req_payload.crop_left});
   assign crop_t_s = $signed({1'b0, req_payload.crop_top});

   assign adj_line_x  = K_LINE  * cfg.step_x_per_line;
   assign adj_pixel_x = K_PIXEL * cfg.step_x_per_pixel;
   assign adj_line_y  = K_LINE  * cfg.step_y_per_line;
   assign adj_pixel_y = K_PIXEL * cfg.step_y_per_pixel;

   assign crop_px_x = crop_l_s * cfg.step_x_per_pixel;
   assign crop_ln_x = crop_t_s * cfg.step_x_per_line;
   assign crop_px_y = crop_l_s * cfg.step_y_per_pixel;
   assign crop_ln_y = crop_t_s * cfg.step_y_per_line;

   assign start_term_x = {{8{cfg.start_x[15]}}, cfg.start_x, 8'd0};
   assign start_term_y = {{8{cfg.start_y[15]}}, cfg.start_y, 8'd0};

   assign base_pre_x = start_term_x - 32'(adj_line_x) - 32'(adj_pixel_x);
   assign base_pre_y = start_term_y - 32'(adj_line_y) - 32'(adj_pixel_y);

   always_comb begin
      stage_in.kind      = req_payload.kind;
      stage_in.base_x    = base_pre_x << STEP_SHIFT;
      stage_in.base_y    = base_pre_y << STEP_SHIFT;
      stage_in.crop_px_x = 32'(crop_px_x) << STEP_SHIFT;
      stage_in.crop_ln_x = 32'(crop_ln_x) << STEP_SHIFT;
      stage_in.crop_px_y = 32'(crop_px_y) << STEP_SHIFT;
      stage_in.crop_ln_y = 32'(crop_ln_y) << STEP_SHIFT;
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (load) begin
         stage_valid_in = 1'b1;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

/* design/roz_accum.sv */
// Row and pixel accumulators with the result register.
module roz_accum #(
   parameter int LAYER_BITS = 9
) (
   input  logic               clock,
   input  logic               reset,
   input  roz_pkg::cfg_type   cfg,
   input  logic               stage_fire,
   input  roz_pkg::stage_type stage,
   output logic               out_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output roz_pkg::rsp_type   rsp_payload
);
   import roz_pkg::*;

   localparam logic [15:0] LAYER_MASK = 16'((1 << LAYER_BITS) - 1);
   localparam int          LIMIT_SHIFT = LAYER_BITS + FRAC_BITS;

   logic [31:0] row_acc_x_ff, row_acc_x_in, row_acc_y_ff, row_acc_y_in;
   logic [31:0] pixel_acc_x_ff, pixel_acc_x_in, pixel_acc_y_ff, pixel_acc_y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [31:0] px_step_x, px_step_y, ln_step_x, ln_step_y;
   logic [31:0] frame_x, frame_y, next_row_x, next_row_y;
   logic [15:0] coord_x, coord_y;
   logic        in_layer, take_pixel;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign take_pixel = stage_fire && stage.kind == KIND_PIXEL;

   assign px_step_x = {{11{cfg.step_x_per_pixel[15]}}, cfg.step_x_per_pixel, 5'd0};
   assign px_step_y = {{11{cfg.step_y_per_pixel[15]}}, cfg.step_y_per_pixel, 5'd0};
   assign ln_step_x = {{11{cfg.step_x_per_line[15]}}, cfg.step_x_per_line, 5'd0};
   assign ln_step_y = {{11{cfg.step_y_per_line[15]}}, cfg.step_y_per_line, 5'd0};

   assign frame_x    = stage.base_x + stage.crop_px_x + stage.crop_ln_x;
   assign frame_y    = stage.base_y + stage.crop_px_y + stage.crop_ln_y;
   assign next_row_x = row_acc_x_ff + ln_step_x;
   assign next_row_y = row_acc_y_ff + ln_step_y;

   assign coord_x  = pixel_acc_x_ff[31:16] & LAYER_MASK;
   assign coord_y  = pixel_acc_y_ff[31:16] & LAYER_MASK;
   assign in_layer = ((pixel_acc_x_ff >> LIMIT_SHIFT) == 32'd0)
                  && ((pixel_acc_y_ff >> LIMIT_SHIFT) == 32'd0);

   always_comb begin
      row_acc_x_in   = row_acc_x_ff;
      row_acc_y_in   = row_acc_y_ff;
      pixel_acc_x_in = pixel_acc_x_ff;
      pixel_acc_y_in = pixel_acc_y_ff;
      if (stage_fire) begin
         case (stage.kind)
            KIND_FRAME: begin
               row_acc_x_in   = frame_x;
               row_acc_y_in   = frame_y;
               pixel_acc_x_in = frame_x;
               pixel_acc_y_in = frame_y;
            end
            KIND_PIXEL: begin
               pixel_acc_x_in = pixel_acc_x_ff + px_step_x;
               pixel_acc_y_in = pixel_acc_y_ff + px_step_y;
            end
            KIND_LINE: begin
               row_acc_x_in   = next_row_x;
               row_acc_y_in   = next_row_y;
               pixel_acc_x_in = next_row_x;
               pixel_acc_y_in = next_row_y;
            end
            default: begin
               row_acc_x_in = row_acc_x_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.source_x   = coord_x[8:0];
      rsp_in.source_y   = coord_y[8:0];
      rsp_in.inside_res = cfg.wrap_mode || in_layer;
      rsp_valid_in      = rsp_valid_ff;
      if (take_pixel) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_acc_x_ff   <= '0;
         row_acc_y_ff   <= '0;
         pixel_acc_x_ff <= '0;
         pixel_acc_y_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         row_acc_x_ff   <= row_acc_x_in;
         row_acc_y_ff   <= row_acc_y_in;
         pixel_acc_x_ff <= pixel_acc_x_in;
         pixel_acc_y_ff <= pixel_acc_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_pixel) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* design/roz_affine_source_address.sv */
// Top level of the rotate-and-zoom source address generator.
//
// Usage: configure start and step registers through the csr_ port while no
// transaction is in flight. Then send a frame-start transaction (kind 0,
// carrying the crop origin), one pixel transaction (kind 1) per screen pixel
// and one line-end transaction (kind 2) per screen line on the req_ channel.
// Each pixel transaction yields one rsp_ transaction with the layer
// coordinate and the in-layer flag (always set in wrap mode); frame-start,
// line-end and kind 3 yield none. A result passes the input register, then
// the result register, before it is valid. Throughput: one transaction per
// cycle while the receiver does not stall. When the receiver stalls, the
// result register holds and the input register keeps taking transactions
// until a second pixel waits behind it; frame-start and line-end pass
// through regardless. Reset clears all configuration registers, all
// accumulators and both valid flags.
module roz_affine_source_address #(
   parameter int LAYER_BITS = 9,
   parameter int X_ADJUST   = 0,
   parameter int Y_ADJUST   = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  roz_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output roz_pkg::rsp_type               rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [roz_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [roz_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [roz_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import roz_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      stage_fire;
   logic      out_ready;

   roz_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   roz_front #(
      .X_ADJUST (X_ADJUST),
      .Y_ADJUST (Y_ADJUST)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .out_ready   (out_ready),
      .stage_fire  (stage_fire),
      .stage       (stage)
   );

   roz_accum #(
      .LAYER_BITS (LAYER_BITS)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .stage_fire  (stage_fire),
      .stage       (stage),
      .out_ready   (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
